FILE: sv/cdp_pkg.sv
// Package for the directory chunk parser: constants, phase codes and shared types.
// No dependencies.
package cdp_pkg;

	localparam int unsigned MAX_CHUNK_BYTES = 65536;
	localparam int unsigned VARINT_MAX_BYTES = 10;
	localparam logic [16:0] MIN_CHUNK = 17'd32;
	localparam logic [16:0] ENTRY_START = 17'd20;
	localparam logic [16:0] COUNT_SAT = 17'h1FFFF;
	localparam logic [27:0] NAME_LEN_MAX = 28'hFFFFFFF;
	localparam logic [31:0] SIG_RESET = 32'd1279741264;
	localparam logic [16:0] SIZE_RESET = 17'd4096;

	typedef enum logic [3:0] {
		PH_SIG   = 4'd0,
		PH_FREE  = 4'd1,
		PH_HDR   = 4'd2,
		PH_ENTRY = 4'd3,
		PH_NAME  = 4'd4,
		PH_TAIL  = 4'd5,
		PH_SKIP  = 4'd6
	} phase_t;

	typedef enum logic [1:0] {
		K_NAME  = 2'd0,
		K_ENTRY = 2'd1,
		K_CHUNK = 2'd2,
		K_ERROR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		E_VARINT = 3'd0,
		E_NAMELEN = 3'd1,
		E_FREE = 3'd2,
		E_OVERRUN = 3'd3,
		E_COUNT = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		R_SIZE = 2'd0,
		R_TOTAL = 2'd1,
		R_SIG = 2'd2
	} reg_t;

	// One classified byte handed from the front to the back.
	typedef struct packed {
		logic [7:0]  data;
		phase_t      phase;
		logic [16:0] pos;
		logic [16:0] size;
		logic [16:0] limit;
		logic        last;
		logic        final_c;
	} op_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_char;
		logic [63:0] entry_section;
		logic [63:0] entry_offset;
		logic [63:0] entry_length;
		logic [15:0] items_in_chunk;
		logic        final_chunk;
		logic [2:0]  error_code;
	} res_t;

endpackage

FILE: sv/cdp_if.sv
// Valid/ready stream interfaces for input bytes and result items.
// Depends on cdp_pkg.
interface cdp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface cdp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  name_char;
	logic [63:0] entry_section;
	logic [63:0] entry_offset;
	logic [63:0] entry_length;
	logic [15:0] items_in_chunk;
	logic        final_chunk;
	logic [2:0]  error_code;
	modport source (output valid, output kind, output name_char, output entry_section,
		output entry_offset, output entry_length, output items_in_chunk,
		output final_chunk, output error_code, input ready);
	modport sink (input valid, input kind, input name_char, input entry_section,
		input entry_offset, input entry_length, input items_in_chunk,
		input final_chunk, input error_code, output ready);
endinterface

FILE: sv/cdp_front.sv
// Front part: tracks chunk position and framing, gathers the header words, and
// tags each byte with its phase. Depends on cdp_pkg.
module cdp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_data,
	input  logic [16:0]          chunk_size,
	input  logic [15:0]          chunk_total,
	input  logic [31:0]          listing_signature,
	input  logic                 halted,
	input  logic                 q_full,
	output logic                 q_push,
	output cdp_pkg::op_t         q_op
);
	import cdp_pkg::*;

	phase_t      phase_q;
	logic [16:0] pos_q;
	logic [15:0] seen_q;
	logic [31:0] gather_q;
	logic [16:0] free_q;
	logic [16:0] size;
	logic [16:0] limit;
	logic [31:0] gw;
	logic        active;
	logic        take;
	logic        end_c;
	phase_t      nph;

	// Clamp the chunk size into its legal range.
	always_comb begin
		size = chunk_size;
		if (chunk_size < MIN_CHUNK) size = MIN_CHUNK;
		else if (chunk_size > 17'(MAX_CHUNK_BYTES)) size = 17'(MAX_CHUNK_BYTES);
	end

	assign limit = (free_q > size) ? 17'd0 : size - free_q;
	assign active = !halted && (seen_q < chunk_total);
	assign in_ready = !q_full || !active;
	assign take = in_valid && in_ready && active;
	assign gw = {in_data, gather_q[31:8]};
	assign end_c = ({1'b0, pos_q} + 18'd1) >= {1'b0, size};

	// Next phase of the framing walk; entry-level phase changes are mirrored here
	// only where they depend on framing alone (the back owns entry decoding).
	always_comb begin
		nph = phase_q;
		case (phase_q)
			PH_SIG: if (pos_q >= 17'd3)
				nph = (gw == listing_signature) ? PH_FREE : PH_SKIP;
			PH_FREE: if (pos_q >= 17'd7) nph = PH_HDR;
			PH_HDR: if (pos_q + 17'd1 >= ENTRY_START) nph = PH_ENTRY;
			PH_ENTRY, PH_NAME, PH_TAIL, PH_SKIP: if (end_c) nph = PH_SIG;
			default: nph = PH_SIG;
		endcase
	end

	assign q_push = take;
	always_comb begin
		q_op.data = in_data;
		q_op.phase = (phase_q == PH_NAME || phase_q == PH_TAIL) ? PH_ENTRY : phase_q;
		q_op.pos = pos_q;
		q_op.size = size;
		q_op.limit = (phase_q == PH_HDR) ? size - free_q : limit;
		q_op.last = end_c;
		q_op.final_c = (seen_q + 16'd1) == chunk_total;
		if (phase_q == PH_FREE) q_op.limit = 17'(gw[16:0]);
		if (phase_q == PH_FREE && gw > {15'd0, size}) q_op.limit = 17'h1FFFF;
		if (phase_q == PH_FREE && gw < 32'd2) q_op.limit = 17'h1FFFF;
	end

	// Framing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			pos_q <= '0;
			seen_q <= '0;
			gather_q <= '0;
			free_q <= '0;
		end else if (take) begin
			if (phase_q == PH_SIG || phase_q == PH_FREE) gather_q <= gw;
			if (phase_q == PH_FREE && pos_q >= 17'd7) free_q <= gw[16:0];
			phase_q <= nph;
			if ((phase_q != PH_SIG && phase_q != PH_FREE && phase_q != PH_HDR) && end_c) begin
				pos_q <= '0;
				seen_q <= seen_q + 16'd1;
			end else begin
				pos_q <= pos_q + 17'd1;
			end
		end
	end

endmodule

FILE: sv/cdp_queue.sv
// Short queue between the front and the back. Depends on cdp_pkg.
module cdp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cdp_pkg::op_t  din,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output cdp_pkg::op_t  dout
);
	import cdp_pkg::*;

	op_t        mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	assign full = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign dout = mem_q[rd_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= din;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 2'd1;
			if (pop && !empty) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push && !full) - 3'(pop && !empty);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count out of range");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> cnt_q == 3'd4)
		else $error("queue overfilled");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		empty && !push |=> empty)
		else $error("queue underflow");

endmodule

FILE: sv/cdp_back.sv
// Back part: decodes entries and checks a classified byte stream, producing
// result items through a two-entry output buffer. Depends on cdp_pkg.
module cdp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  cdp_pkg::op_t  q_op,
	output logic          q_pop,
	output logic          halted,
	output logic          out_valid,
	input  logic          out_ready,
	output cdp_pkg::res_t out_res
);
	import cdp_pkg::*;

	// Entry decode state.
	phase_t      sub_q;
	logic [63:0] acc_q;
	logic [3:0]  nb_q;
	logic [1:0]  fsel_q;
	logic [27:0] nleft_q;
	logic        ndone_q;
	logic [16:0] items_q;
	logic [63:0] sec_q;
	logic [63:0] off_q;
	logic [7:0]  low_q;
	logic        halt_q;

	// Two-entry output buffer.
	res_t        ob_q [2];
	logic        ob_rd_q;
	logic        ob_wr_q;
	logic [1:0]  ob_cnt_q;

	logic        go;
	logic        emit;
	res_t        r;
	logic [63:0] acc_n;
	logic [15:0] cnt;
	logic [16:0] limit;

	assign halted = halt_q;
	assign go = !q_empty && !halt_q && ob_cnt_q != 2'd2;
	assign q_pop = go || (!q_empty && halt_q);
	assign acc_n = {acc_q[56:0], q_op.data[6:0]};
	assign cnt = {q_op.data, low_q};
	assign limit = q_op.limit;

	// Result for the byte at the queue head.
	always_comb begin
		emit = 1'b0;
		r = '0;
		if (go) begin
			case (q_op.phase)
				PH_FREE: if (q_op.pos >= 17'd7 && limit == 17'h1FFFF) begin
					emit = 1'b1; r.kind = K_ERROR; r.error_code = E_FREE;
				end
				PH_HDR: if (q_op.pos + 17'd1 >= ENTRY_START && limit < ENTRY_START) begin
					emit = 1'b1; r.kind = K_ERROR; r.error_code = E_OVERRUN;
				end
				PH_ENTRY: begin
					if (sub_q == PH_TAIL) begin
						if (q_op.last) begin
							emit = 1'b1;
							if ({1'b0, cnt} != items_q) begin
								r.kind = K_ERROR; r.error_code = E_COUNT;
							end else begin
								r.kind = K_CHUNK; r.items_in_chunk = items_q[15:0];
								r.final_chunk = q_op.final_c;
							end
						end
					end else if (q_op.pos >= limit) begin
						emit = 1'b1; r.kind = K_ERROR; r.error_code = E_OVERRUN;
					end else if (sub_q == PH_NAME) begin
						if (!ndone_q && q_op.data != 8'd0) begin
							emit = 1'b1; r.kind = K_NAME; r.name_char = q_op.data;
						end
					end else if (q_op.data[7]) begin
						if (nb_q + 4'd1 >= 4'(VARINT_MAX_BYTES)) begin
							emit = 1'b1; r.kind = K_ERROR; r.error_code = E_VARINT;
						end
					end else if (fsel_q == 2'd0) begin
						if (acc_n == 64'd0 || acc_n > {36'd0, NAME_LEN_MAX}) begin
							emit = 1'b1; r.kind = K_ERROR; r.error_code = E_NAMELEN;
						end
					end else if (fsel_q == 2'd3) begin
						emit = 1'b1; r.kind = K_ENTRY; r.entry_section = sec_q;
						r.entry_offset = off_q; r.entry_length = acc_n;
					end
				end
				PH_SKIP: if (q_op.last) begin
					emit = 1'b1; r.kind = K_CHUNK; r.final_chunk = q_op.final_c;
				end
				default: emit = 1'b0;
			endcase
		end
	end

	// Decode state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= PH_ENTRY;
			acc_q <= '0;
			nb_q <= '0;
			fsel_q <= '0;
			nleft_q <= '0;
			ndone_q <= 1'b0;
			items_q <= '0;
			sec_q <= '0;
			off_q <= '0;
			low_q <= '0;
			halt_q <= 1'b0;
		end else if (go) begin
			if (emit && r.kind == K_ERROR) halt_q <= 1'b1;
			if (emit && r.kind == K_CHUNK) items_q <= '0;
			case (q_op.phase)
				// The low byte of the gathered free length stands as the count's low
				// byte until the tail supplies its own.
				PH_FREE: if (q_op.pos == 17'd4) low_q <= q_op.data;
				PH_HDR: begin
					sub_q <= (limit == ENTRY_START) ? PH_TAIL : PH_ENTRY;
					fsel_q <= '0; acc_q <= '0; nb_q <= '0;
				end
				PH_ENTRY: begin
					if (sub_q == PH_TAIL) begin
						if (q_op.pos + 17'd2 == q_op.size) low_q <= q_op.data;
					end else if (sub_q == PH_NAME) begin
						if (q_op.data == 8'd0) ndone_q <= 1'b1;
						nleft_q <= nleft_q - 28'd1;
						if (nleft_q == 28'd1) begin
							sub_q <= PH_ENTRY; fsel_q <= 2'd1;
						end
					end else if (q_op.data[7]) begin
						acc_q <= acc_n; nb_q <= nb_q + 4'd1;
					end else begin
						acc_q <= '0; nb_q <= '0;
						case (fsel_q)
							2'd0: begin
								nleft_q <= acc_n[27:0]; ndone_q <= 1'b0; sub_q <= PH_NAME;
							end
							2'd1: begin sec_q <= acc_n; fsel_q <= 2'd2; end
							2'd2: begin off_q <= acc_n; fsel_q <= 2'd3; end
							default: begin
								if (items_q < COUNT_SAT) items_q <= items_q + 17'd1;
								fsel_q <= 2'd0;
								if (q_op.pos + 17'd1 >= limit) sub_q <= PH_TAIL;
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// Output buffer.
	assign out_valid = ob_cnt_q != 2'd0;
	assign out_res = ob_q[ob_rd_q];
	always_ff @(posedge clk) begin
		if (emit) ob_q[ob_wr_q] <= r;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_rd_q <= 1'b0;
			ob_wr_q <= 1'b0;
			ob_cnt_q <= '0;
		end else begin
			if (emit) ob_wr_q <= !ob_wr_q;
			if (out_valid && out_ready) ob_rd_q <= !ob_rd_q;
			ob_cnt_q <= ob_cnt_q + 2'(emit) - 2'(out_valid && out_ready);
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q) else $error("halt cleared");
	a_no_emit_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> !emit) else $error("result after halt");
	a_ob_count: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q != 2'd3) else $error("output buffer overfilled");

endmodule

FILE: sv/chm_directory_chunk_parser.sv
// Directory chunk parser top level: APB register file, front, queue and back.
// Depends on cdp_pkg, cdp_if, cdp_front, cdp_queue and cdp_back.
//
// Takes one byte per clock when the result side keeps up: the front frames
// chunks and tags each byte, a four-deep queue decouples it from the back, and
// the back decodes entries into a two-entry output buffer, so each byte gives
// at most one result. After an error result the block drops
// further bytes until reset; once chunk_total chunks are done bytes are taken
// and dropped.
module chm_directory_chunk_parser (
	input  logic        clk,
	input  logic        arst_n,
	cdp_in_if.sink      in_ch,
	cdp_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cdp_pkg::*;

	logic [16:0] size_q;
	logic [15:0] total_q;
	logic [31:0] sig_q;
	logic        halted;
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_empty;
	op_t         op_in;
	op_t         op_out;
	res_t        res;

	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			total_q <= '0;
			sig_q <= SIG_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_t'(paddr[3:2]))
				R_SIZE: size_q <= pwdata[16:0];
				R_TOTAL: total_q <= pwdata[15:0];
				R_SIG: sig_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_t'(paddr[3:2]))
			R_SIZE: prdata = {15'd0, size_q};
			R_TOTAL: prdata = {16'd0, total_q};
			R_SIG: prdata = sig_q;
			default: prdata = '0;
		endcase
	end

	cdp_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data_byte),
		.chunk_size(size_q), .chunk_total(total_q), .listing_signature(sig_q),
		.halted, .q_full, .q_push, .q_op(op_in)
	);

	cdp_queue u_queue (
		.clk, .arst_n, .push(q_push), .din(op_in), .full(q_full),
		.pop(q_pop), .empty(q_empty), .dout(op_out)
	);

	cdp_back u_back (
		.clk, .arst_n, .q_empty, .q_op(op_out), .q_pop, .halted,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
	);

	assign out_ch.kind = res.kind;
	assign out_ch.name_char = res.name_char;
	assign out_ch.entry_section = res.entry_section;
	assign out_ch.entry_offset = res.entry_offset;
	assign out_ch.entry_length = res.entry_length;
	assign out_ch.items_in_chunk = res.items_in_chunk;
	assign out_ch.final_chunk = res.final_chunk;
	assign out_ch.error_code = res.error_code;

endmodule

FILE: dv/chm_directory_chunk_parser_test.sv
// Self-checking testbench for the directory chunk parser: directed listing chunks, then
// random listing, foreign and malformed chunks under random flow control on both streams.
// Depends on cdp_pkg, cdp_if and chm_directory_chunk_parser.
module chm_directory_chunk_parser_test;
	import cdp_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_BYTES = 1200;

	typedef enum int {
		CF_LISTING,
		CF_OTHER,
		CF_BAD_VARINT,
		CF_BAD_NAMELEN,
		CF_BAD_FREE,
		CF_OVERRUN,
		CF_BAD_COUNT
	} chunk_form_t;

	// One byte for the input stream, optionally with a hand-written expectation.
	typedef struct {
		logic [7:0] b;
		logic       typed;
		res_t       want;
	} feed_t;

	// One line of the directed table: a byte repeated reps times.
	typedef struct {
		logic [7:0] b;
		int         reps;
		logic       typed;
		res_t       want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	cdp_in_if in_ch();
	cdp_out_if out_ch();

	chm_directory_chunk_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	feed_t feed_q[$];
	res_t want_q[$];
	res_t parsed_q[$];

	int mismatches = 0;
	int results_seen = 0;
	int bytes_sent = 0;
	int chunks_done = 0;
	int idle_cycles = 0;
	int error_hit = -1;

	// Register copies kept alongside the block.
	logic [16:0] cfg_size = SIZE_RESET;
	logic [15:0] cfg_total = '0;
	logic [31:0] cfg_sig = SIG_RESET;

	// Parser state as the block should hold it.
	phase_t      st_phase = PH_SIG;
	logic [16:0] st_pos = '0;
	logic [15:0] st_seen = '0;
	logic [31:0] st_gather = '0;
	logic [16:0] st_free = '0;
	logic [63:0] st_acc = '0;
	int          st_vbytes = 0;
	logic [1:0]  st_field = '0;
	logic [27:0] st_name_left = '0;
	logic        st_name_done = 1'b0;
	logic [16:0] st_items = '0;
	logic [63:0] st_section = '0;
	logic [63:0] st_offset = '0;
	logic        st_halted = 1'b0;

	function automatic res_t make_res(kind_t k, logic [7:0] ch, logic [63:0] sec,
			logic [63:0] off, logic [63:0] len, logic [15:0] items, logic fin,
			logic [2:0] err);
		res_t r;
		r.kind = k;
		r.name_char = ch;
		r.entry_section = sec;
		r.entry_offset = off;
		r.entry_length = len;
		r.items_in_chunk = items;
		r.final_chunk = fin;
		r.error_code = err;
		return r;
	endfunction

	function automatic int unsigned clamped_size();
		int unsigned s;
		s = cfg_size;
		if (s < 32) s = 32;
		if (s > MAX_CHUNK_BYTES) s = MAX_CHUNK_BYTES;
		return s;
	endfunction

	task automatic parse_fail(err_t code);
		st_halted = 1'b1;
		parsed_q.insert(parsed_q.size(),
			make_res(K_ERROR, 8'h0, '0, '0, '0, 16'h0, 1'b0, code));
	endtask

	task automatic close_chunk(logic [16:0] items);
		logic fin;
		fin = (int'(st_seen) + 1 == int'(cfg_total));
		parsed_q.insert(parsed_q.size(),
			make_res(K_CHUNK, 8'h0, '0, '0, '0, items[15:0], fin, 3'd0));
		st_seen = st_seen + 16'd1;
		st_pos = '0;
		st_phase = PH_SIG;
		st_items = '0;
	endtask

	// Advances the parser state by one stream byte, queueing what it emits.
	task automatic parse_byte(logic [7:0] b);
		int unsigned size, pos, limit;
		logic [63:0] v;
		logic [16:0] cnt;
		if (st_halted || int'(st_seen) >= int'(cfg_total))
			return;
		size = clamped_size();
		pos = st_pos;
		limit = (st_free > size) ? 0 : size - st_free;
		case (st_phase)
			PH_SIG: begin
				st_gather = {b, st_gather[31:8]};
				if (pos >= 3)
					st_phase = (st_gather == cfg_sig) ? PH_FREE : PH_SKIP;
			end
			PH_FREE: begin
				st_gather = {b, st_gather[31:8]};
				if (pos >= 7) begin
					if (st_gather > size || st_gather < 2) begin
						parse_fail(E_FREE);
						return;
					end
					st_free = st_gather[16:0];
					st_phase = PH_HDR;
				end
			end
			PH_HDR: begin
				if (pos + 1 >= ENTRY_START) begin
					limit = size - st_free;
					if (limit < ENTRY_START) begin
						parse_fail(E_OVERRUN);
						return;
					end
					if (limit == ENTRY_START) begin
						st_phase = PH_TAIL;
					end else begin
						st_phase = PH_ENTRY;
						st_field = '0;
						st_acc = '0;
						st_vbytes = 0;
					end
				end
			end
			PH_ENTRY: begin
				if (pos >= limit) begin
					parse_fail(E_OVERRUN);
					return;
				end
				st_acc = {st_acc[56:0], b[6:0]};
				st_vbytes++;
				if (b[7]) begin
					if (st_vbytes >= VARINT_MAX_BYTES) begin
						parse_fail(E_VARINT);
						return;
					end
				end else begin
					v = st_acc;
					st_acc = '0;
					st_vbytes = 0;
					if (st_field == 2'd0) begin
						if (v == 0 || v > NAME_LEN_MAX) begin
							parse_fail(E_NAMELEN);
							return;
						end
						st_name_left = v[27:0];
						st_name_done = 1'b0;
						st_phase = PH_NAME;
					end else if (st_field == 2'd1) begin
						st_section = v;
						st_field = 2'd2;
					end else if (st_field == 2'd2) begin
						st_offset = v;
						st_field = 2'd3;
					end else begin
						parsed_q.insert(parsed_q.size(), make_res(K_ENTRY, 8'h0, st_section,
							st_offset, v, 16'h0, 1'b0, 3'd0));
						if (st_items < COUNT_SAT)
							st_items++;
						st_field = 2'd0;
						if (pos + 1 >= limit)
							st_phase = PH_TAIL;
					end
				end
			end
			PH_NAME: begin
				if (pos >= limit) begin
					parse_fail(E_OVERRUN);
					return;
				end
				if (!st_name_done) begin
					if (b == 8'h0)
						st_name_done = 1'b1;
					else
						parsed_q.insert(parsed_q.size(),
							make_res(K_NAME, b, '0, '0, '0, 16'h0, 1'b0, 3'd0));
				end
				st_name_left = st_name_left - 28'd1;
				if (st_name_left == '0) begin
					st_phase = PH_ENTRY;
					st_field = 2'd1;
				end
			end
			PH_TAIL: begin
				if (pos + 1 >= size) begin
					cnt = {1'b0, b, st_gather[7:0]};
					if (cnt != st_items)
						parse_fail(E_COUNT);
					else
						close_chunk(st_items);
					return;
				end
				if (pos + 2 == size)
					st_gather = {24'h0, b};
			end
			default: begin
				if (pos + 1 >= size) begin
					close_chunk('0);
					return;
				end
			end
		endcase
		st_pos = 17'(pos + 1);
	endtask

	// Register write: setup cycle, then access cycle; the mirror follows at the access edge.
	task automatic reg_write(reg_t r, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			R_SIZE: cfg_size = v[16:0];
			R_TOTAL: cfg_total = v[15:0];
			default: cfg_sig = v;
		endcase
	endtask

	// Waits for all queued bytes and results, then lets the pipeline empty.
	task automatic settle();
		while (feed_q.size() != 0 || in_ch.valid || want_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send(logic [7:0] b);
		feed_t f;
		f.b = b;
		f.typed = 1'b0;
		f.want = '0;
		feed_q.insert(feed_q.size(), f);
	endtask

	task automatic add_varint(ref logic [7:0] buf_q[$]);
		int n;
		logic [7:0] v;
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, VARINT_MAX_BYTES)
			: $urandom_range(1, 2);
		for (int i = 0; i < n; i++) begin
			v = 8'($urandom);
			v[7] = (i < n - 1);
			buf_q.insert(buf_q.size(), v);
		end
	endtask

	task automatic add_entry(ref logic [7:0] buf_q[$]);
		int len;
		len = $urandom_range(1, 6);
		// A redundant leading group leaves the name length unchanged.
		if ($urandom_range(0, 3) == 0)
			buf_q.insert(buf_q.size(), 8'h80);
		buf_q.insert(buf_q.size(), len[7:0]);
		for (int i = 0; i < len; i++)
			buf_q.insert(buf_q.size(),
				($urandom_range(0, 3) == 0) ? 8'h0 : 8'($urandom_range(1, 255)));
		repeat (3) add_varint(buf_q);
	endtask

	// Queues one chunk of the current size; malformed chunks stop where the error fires.
	task automatic queue_chunk(chunk_form_t form);
		int unsigned sz, free_bytes, keep;
		logic [7:0] body[$];
		logic [7:0] ent[$];
		logic [7:0] one[$];
		logic [15:0] count;
		int entries;
		sz = clamped_size();
		entries = 0;
		if (form == CF_OTHER) begin
			for (int i = 0; i < sz; i++)
				body.insert(body.size(), 8'($urandom));
			if ({body[3], body[2], body[1], body[0]} == cfg_sig)
				body[0] = body[0] ^ 8'h01;
			foreach (body[i]) send(body[i]);
			return;
		end
		for (int i = 0; i < 4; i++)
			body.insert(body.size(), cfg_sig[8 * i +: 8]);
		if (form == CF_BAD_VARINT) begin
			repeat (VARINT_MAX_BYTES) ent.insert(ent.size(), 8'h80);
		end else if (form == CF_BAD_NAMELEN) begin
			ent.insert(ent.size(), 8'h00);
		end else if (form != CF_OVERRUN) begin
			repeat ($urandom_range(0, 8)) begin
				one.delete();
				add_entry(one);
				if (ent.size() + one.size() <= sz - 22) begin
					foreach (one[i]) ent.insert(ent.size(), one[i]);
					entries++;
				end
			end
		end
		free_bytes = sz - 20 - ent.size();
		keep = sz;
		if (form == CF_BAD_FREE) begin
			free_bytes = $urandom_range(0, 1) ? $urandom_range(0, 1) : sz + $urandom_range(1, 300);
			keep = 8;
		end else if (form == CF_OVERRUN) begin
			free_bytes = sz - $urandom_range(0, 19);
			keep = 20;
		end else if (form == CF_BAD_VARINT || form == CF_BAD_NAMELEN) begin
			keep = 20 + ent.size();
		end
		for (int i = 0; i < 4; i++)
			body.insert(body.size(), free_bytes[8 * i +: 8]);
		repeat (12) body.insert(body.size(), 8'($urandom));
		foreach (ent[i]) body.insert(body.size(), ent[i]);
		while (body.size() < sz - 2)
			body.insert(body.size(), 8'($urandom));
		count = 16'(entries);
		if (form == CF_BAD_COUNT)
			count = count ^ (16'h1 << $urandom_range(0, 15));
		body.insert(body.size(), count[7:0]);
		body.insert(body.size(), count[15:8]);
		for (int i = 0; i < keep; i++)
			send(body[i]);
	endtask

	// Input side: bursts of random length separated by random gaps.
	feed_t cur;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				bytes_sent++;
				parsed_q.delete();
				parse_byte(cur.b);
				if (cur.typed)
					want_q.insert(want_q.size(), cur.want);
				else
					foreach (parsed_q[i]) want_q.insert(want_q.size(), parsed_q[i]);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (feed_q.size() != 0) begin
					cur = feed_q.pop_front();
					in_ch.data_byte <= cur.b;
					in_ch.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result side: stall pattern that switches between random modes.
	int stall_mode = 0;
	int mode_left = 0;
	int stall_tick = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(64, 256);
			end
			mode_left--;
			stall_tick++;
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				default: out_ch.ready <= (stall_tick % 5 > 1);
			endcase
		end
	end

	// Compares every result transfer with the oldest expectation.
	always @(posedge clk) begin
		res_t got, exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = make_res(kind_t'(out_ch.kind), out_ch.name_char, out_ch.entry_section,
				out_ch.entry_offset, out_ch.entry_length, out_ch.items_in_chunk,
				out_ch.final_chunk, out_ch.error_code);
			results_seen++;
			if (got.kind == K_CHUNK)
				chunks_done++;
			if (got.kind == K_ERROR)
				error_hit = got.error_code;
			if (want_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: kind %0d code %0d", got.kind, got.error_code);
			end else begin
				exp_r = want_q.pop_front();
				if (got.kind !== exp_r.kind || got.name_char !== exp_r.name_char
						|| got.entry_section !== exp_r.entry_section
						|| got.entry_offset !== exp_r.entry_offset
						|| got.entry_length !== exp_r.entry_length
						|| got.items_in_chunk !== exp_r.items_in_chunk
						|| got.final_chunk !== exp_r.final_chunk
						|| got.error_code !== exp_r.error_code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected k%0d c%h s%h o%h l%h n%0d f%0d e%0d, got k%0d c%h s%h o%h l%h n%0d f%0d e%0d",
							exp_r.kind, exp_r.name_char, exp_r.entry_section,
							exp_r.entry_offset, exp_r.entry_length, exp_r.items_in_chunk,
							exp_r.final_chunk, exp_r.error_code, got.kind, got.name_char,
							got.entry_section, got.entry_offset, got.entry_length,
							got.items_in_chunk, got.final_chunk, got.error_code);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Directed chunks at 64 bytes: an empty listing, then one with two entries whose
	// names and fields sit at their extremes, then bytes past the last chunk.
	dir_row_t dir_tab [0:35] = '{
		'{8'h50, 1, 1'b0, '0}, '{8'h4D, 1, 1'b0, '0},
		'{8'h47, 1, 1'b0, '0}, '{8'h4C, 1, 1'b0, '0},
		'{8'h2C, 1, 1'b0, '0}, '{8'h00, 3, 1'b0, '0},
		'{8'h00, 12, 1'b0, '0}, '{8'hFF, 42, 1'b0, '0},
		'{8'h00, 1, 1'b0, '0},
		'{8'h00, 1, 1'b1, '{K_CHUNK, 8'h0, 64'h0, 64'h0, 64'h0, 16'd0, 1'b0, 3'd0}},
		'{8'h50, 1, 1'b0, '0}, '{8'h4D, 1, 1'b0, '0},
		'{8'h47, 1, 1'b0, '0}, '{8'h4C, 1, 1'b0, '0},
		'{8'h14, 1, 1'b0, '0}, '{8'h00, 3, 1'b0, '0},
		'{8'h00, 12, 1'b0, '0}, '{8'h03, 1, 1'b0, '0},
		'{8'hFF, 1, 1'b1, '{K_NAME, 8'hFF, 64'h0, 64'h0, 64'h0, 16'd0, 1'b0, 3'd0}},
		'{8'h00, 1, 1'b0, '0}, '{8'h7A, 1, 1'b0, '0},
		'{8'h00, 1, 1'b0, '0}, '{8'h81, 1, 1'b0, '0},
		'{8'h00, 1, 1'b0, '0}, '{8'hFF, 9, 1'b0, '0},
		'{8'h7F, 1, 1'b1, '{K_ENTRY, 8'h0, 64'h0, 64'd128, '1, 16'd0, 1'b0, 3'd0}},
		'{8'h01, 1, 1'b0, '0},
		'{8'h01, 1, 1'b1, '{K_NAME, 8'h01, 64'h0, 64'h0, 64'h0, 16'd0, 1'b0, 3'd0}},
		'{8'h7F, 1, 1'b0, '0}, '{8'h80, 2, 1'b0, '0},
		'{8'h01, 1, 1'b0, '0},
		'{8'h00, 1, 1'b1, '{K_ENTRY, 8'h0, 64'd127, 64'd1, 64'h0, 16'd0, 1'b0, 3'd0}},
		'{8'h5A, 18, 1'b0, '0}, '{8'h02, 1, 1'b0, '0},
		'{8'h00, 1, 1'b1, '{K_CHUNK, 8'h0, 64'h0, 64'h0, 64'h0, 16'd2, 1'b1, 3'd0}},
		'{8'hAA, 3, 1'b0, '0}
	};

	initial begin
		feed_t f;
		int phase_no, random_bytes, nchunks, queued_at_start;
		chunk_form_t last_form;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part.
		reg_write(R_SIZE, 32'd64);
		reg_write(R_TOTAL, 32'd2);
		reg_write(R_SIG, SIG_RESET);
		foreach (dir_tab[i]) begin
			for (int r = 0; r < dir_tab[i].reps; r++) begin
				f.b = dir_tab[i].b;
				f.typed = dir_tab[i].typed && (r == dir_tab[i].reps - 1);
				f.want = dir_tab[i].want;
				feed_q.insert(feed_q.size(), f);
			end
		end
		settle();

		// Random phases, each with its own register settings.
		phase_no = 0;
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES || phase_no < 13) begin
			case (phase_no)
				3: reg_write(R_SIZE, 32'd0);
				4: reg_write(R_SIZE, 32'd32);
				5: reg_write(R_SIZE, 32'h1FFFF);
				6: reg_write(R_SIZE, 32'd31);
				default: reg_write(R_SIZE, ($urandom_range(0, 3) == 0) ? 32'd32
					: $urandom_range(33, 128));
			endcase
			if (phase_no == 7)
				reg_write(R_SIG, 32'h0);
			else if (phase_no == 9)
				reg_write(R_SIG, 32'hFFFFFFFF);
			else if (phase_no == 11 || $urandom_range(0, 5) == 0)
				reg_write(R_SIG, ($urandom_range(0, 1) == 0) ? SIG_RESET : $urandom);
			nchunks = (phase_no == 5) ? 1 : $urandom_range(1, 2);
			if (phase_no == 12)
				reg_write(R_TOTAL, 32'd65535);
			else
				reg_write(R_TOTAL, st_seen + nchunks);
			queued_at_start = feed_q.size();
			if (phase_no == 5) begin
				// A skipped chunk at the largest size, closed early by shrinking the size.
				send(cfg_sig[7:0] ^ 8'h01);
				repeat (47) send(8'($urandom));
				settle();
				reg_write(R_SIZE, 32'd32);
				send(8'($urandom));
			end else begin
				for (int c = 0; c < nchunks; c++)
					queue_chunk(($urandom_range(0, 4) == 0) ? CF_OTHER : CF_LISTING);
			end
			random_bytes += feed_q.size() - queued_at_start;
			// Bytes past the last configured chunk are dropped without a result.
			if (phase_no != 12 && $urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4)) send(8'($urandom));
			settle();
			phase_no++;
		end

		// Last phase: one malformed chunk, since an error halts the block for good.
		reg_write(R_SIZE, $urandom_range(32, 96));
		reg_write(R_SIG, SIG_RESET);
		reg_write(R_TOTAL, st_seen + 1);
		last_form = chunk_form_t'($urandom_range(CF_BAD_VARINT, CF_BAD_COUNT));
		queue_chunk(last_form);
		settle();

		$display("Covered %0d bytes in %0d phases, %0d results, %0d chunks completed.",
			bytes_sent, phase_no + 2, results_seen, chunks_done);
		$display("Closing error code %0d, %0d mismatches.", error_hit, mismatches);
		if (mismatches == 0 && want_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
